>>> hdl/pmpt_pkg.sv
// Package with shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package pmpt_pkg;

  localparam int POS_BITS  = 12;
  localparam int SIZE_W    = 13;
  localparam int DELTA_W   = 9;
  localparam int BTN_W     = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int CMP_W     = ((POS_BITS + 2) > (SIZE_W + 1)) ? (POS_BITS + 2) : (SIZE_W + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [1:0] REG_WHEEL_ENABLE  = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(768);

  localparam int STATUS_DATA_BIT = 0;
  localparam int STATUS_AUX_BIT  = 5;
  localparam int SYNC_BIT        = 3;
  localparam int SIGN_X_BIT      = 4;
  localparam int SIGN_Y_BIT      = 5;

  typedef struct packed {
    logic              wheel_enable;
    logic [SIZE_W-1:0] x_extent;
    logic [SIZE_W-1:0] y_extent;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/pmpt_if.sv
// Stream interfaces for the input bytes and the tracker results.
`default_nettype none

interface pmpt_in_if;
  import pmpt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] ctrl_status;
  logic [7:0] rx_byte;

  modport source (output valid, output ctrl_status, output rx_byte, input ready);
  modport sink (input valid, input ctrl_status, input rx_byte, output ready);
endinterface

interface pmpt_out_if;
  import pmpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       packet_done;
  logic                       byte_taken;
  logic [BTN_W-1:0]           button_bits;
  logic signed [DELTA_W-1:0]  delta_x;
  logic signed [DELTA_W-1:0]  delta_y;
  logic [POS_BITS-1:0]        pos_x;
  logic [POS_BITS-1:0]        pos_y;

  modport source (output valid, output packet_done, output byte_taken, output button_bits,
                  output delta_x, output delta_y, output pos_x, output pos_y, input ready);
  modport sink (input valid, input packet_done, input byte_taken, input button_bits,
                input delta_x, input delta_y, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

>>> hdl/pmpt_cfg.sv
// APB configuration registers of the packet tracker.
`default_nettype none

module pmpt_cfg
  import pmpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_enable <= 1'b0;
      cfg.x_extent     <= WIDTH_RESET;
      cfg.y_extent     <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_WHEEL_ENABLE:  cfg.wheel_enable <= pwdata[0];
        REG_SCREEN_WIDTH:  cfg.x_extent     <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg.y_extent     <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WHEEL_ENABLE:  prdata = {{(DATA_W-1){1'b0}}, cfg.wheel_enable};
      REG_SCREEN_WIDTH:  prdata = {{(DATA_W-SIZE_W){1'b0}}, cfg.x_extent};
      REG_SCREEN_HEIGHT: prdata = {{(DATA_W-SIZE_W){1'b0}}, cfg.y_extent};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/pmpt_core.sv
// Input register, packet assembly, position update and result register.
`default_nettype none

module pmpt_core
  import pmpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  pmpt_in_if.sink   in_ch,
  pmpt_out_if.source out_ch
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_status;
  logic [7:0] in_data;
  logic       advance;

  // Tracker state.
  logic [1:0]                byte_index;
  logic [7:0]                pkt0;
  logic [7:0]                pkt1;
  logic [7:0]                pkt2;
  logic [POS_BITS-1:0]       cursor_x;
  logic [POS_BITS-1:0]       cursor_y;
  logic [BTN_W-1:0]          last_buttons;
  logic signed [DELTA_W-1:0] last_dx;
  logic signed [DELTA_W-1:0] last_dy;

  logic                      take;
  logic                      done;
  logic [1:0]                last_index;
  logic [7:0]                byte2;
  logic [1:0]                byte_index_next;
  logic signed [DELTA_W-1:0] dx_new;
  logic signed [DELTA_W-1:0] dy_new;
  logic signed [CMP_W-1:0]   sum_x;
  logic signed [CMP_W-1:0]   sum_y;
  logic [POS_BITS-1:0]       cursor_x_next;
  logic [POS_BITS-1:0]       cursor_y_next;

  function automatic logic [CMP_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else begin
      lim = CMP_W'(size) - CMP_W'(1);
    end
    if (lim > CMP_W'(POS_MAX)) begin
      lim = CMP_W'(POS_MAX);
    end
    return lim;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [CMP_W-1:0] v,
                                                   input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] res;
    lim = limit_of(size);
    if (v[CMP_W-1]) begin
      res = '0;
    end else if (CMP_W'(v) > lim) begin
      res = lim;
    end else begin
      res = CMP_W'(v);
    end
    return res[POS_BITS-1:0];
  endfunction

  assign advance     = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_status <= in_ch.ctrl_status;
      in_data   <= in_ch.rx_byte;
    end
  end

  always_comb begin
    take = in_status[STATUS_DATA_BIT] & in_status[STATUS_AUX_BIT]
         & ~((byte_index == 2'd0) & ~in_data[SYNC_BIT]);
    last_index = cfg.wheel_enable ? 2'd3 : 2'd2;
    done = take & (byte_index >= last_index);
    byte2 = (byte_index == 2'd2) ? in_data : pkt2;
    dx_new = {pkt0[SIGN_X_BIT], pkt1};
    dy_new = {pkt0[SIGN_Y_BIT], byte2};
    sum_x = $signed(CMP_W'(cursor_x)) + $signed({{(CMP_W-DELTA_W){dx_new[DELTA_W-1]}}, dx_new});
    sum_y = $signed(CMP_W'(cursor_y)) - $signed({{(CMP_W-DELTA_W){dy_new[DELTA_W-1]}}, dy_new});
    cursor_x_next = clamp_pos(sum_x, cfg.x_extent);
    cursor_y_next = clamp_pos(sum_y, cfg.y_extent);
    if (done) begin
      byte_index_next = 2'd0;
    end else if (take) begin
      byte_index_next = byte_index + 2'd1;
    end else begin
      byte_index_next = byte_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= 2'd0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      last_buttons <= '0;
      last_dx      <= '0;
      last_dy      <= '0;
    end else if (in_valid && advance) begin
      byte_index <= byte_index_next;
      if (done) begin
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        last_buttons <= pkt0[BTN_W-1:0];
        last_dx      <= dx_new;
        last_dy      <= dy_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance && take) begin
      case (byte_index)
        2'd0:    pkt0 <= in_data;
        2'd1:    pkt1 <= in_data;
        2'd2:    pkt2 <= in_data;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_ch.packet_done <= done;
      out_ch.byte_taken  <= take;
      out_ch.button_bits <= done ? pkt0[BTN_W-1:0] : last_buttons;
      out_ch.delta_x     <= done ? dx_new : last_dx;
      out_ch.delta_y     <= done ? dy_new : last_dy;
      out_ch.pos_x       <= done ? cursor_x_next : cursor_x;
      out_ch.pos_y       <= done ? cursor_y_next : cursor_y;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
//
// Bytes arrive on in_ch as transfers of a controller status byte and a data
// byte. Every input transfer yields exactly one result transfer on out_ch,
// carrying the packet-done and byte-taken flags, the buttons and movements of
// the latest complete packet and the clamped cursor position.
// A byte passes through an input register and then a result register; the
// packet and position update between the two registers is combinational.
// One byte is accepted in every cycle while out_ch does not stall.
// If out_ch stalls, the result register holds its transfer. An empty input
// register still takes one more byte; once it is full, in_ch.ready stays low
// for as long as out_ch.ready is low.
// Write the registers over the APB port only while the block is idle; the
// block does not enforce this. Reset clears the packet position, cursor and
// last packet values, and restores three-byte packets on a 1024 by 768 screen.
`default_nettype none

module ps2_mouse_packet_tracker
  import pmpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  pmpt_in_if.sink                in_ch,
  pmpt_out_if.source             out_ch
);

  cfg_t cfg;

  pmpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmpt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the PS/2 mouse packet tracker.
`timescale 1ns / 100ps

module tb_top;
  import pmpt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [7:0] ST_MOUSE = 8'h21;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] data;
  } mouse_byte_t;

  typedef struct packed {
    logic                done;
    logic                taken;
    logic [BTN_W-1:0]    buttons;
    logic [DELTA_W-1:0]  dx;
    logic [DELTA_W-1:0]  dy;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
  } tracker_report_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pmpt_in_if  in_ch ();
  pmpt_out_if out_ch ();

  ps2_mouse_packet_tracker u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  mouse_byte_t     pending_bytes[$];
  tracker_report_t expected_reports[$];
  mouse_byte_t     byte_on_bus;
  int              idle_pct;
  int              stall_pct;
  int              errors;
  int              cycle_count;

  logic                cfg_wheel;
  logic [SIZE_W-1:0]   cfg_width;
  logic [SIZE_W-1:0]   cfg_height;
  int                  trk_index;
  logic [7:0]          trk_bytes[3];
  int                  trk_x;
  int                  trk_y;
  logic [BTN_W-1:0]    trk_buttons;
  int                  trk_dx;
  int                  trk_dy;

  function automatic int pos_limit(logic [SIZE_W-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > int'(POS_MAX)) lim = int'(POS_MAX);
    return lim;
  endfunction

  function automatic int clamp_to(int v, logic [SIZE_W-1:0] size);
    int lim;
    lim = pos_limit(size);
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic tracker_report_t track_byte(mouse_byte_t b);
    tracker_report_t r;
    int pkt_len;
    r.done  = 1'b0;
    r.taken = 1'b0;
    if (b.status[STATUS_DATA_BIT] && b.status[STATUS_AUX_BIT]) begin
      if (!(trk_index == 0 && !b.data[SYNC_BIT])) begin
        pkt_len = cfg_wheel ? 4 : 3;
        r.taken = 1'b1;
        if (trk_index < 3) trk_bytes[trk_index] = b.data;
        if (trk_index + 1 >= pkt_len) begin
          trk_index   = 0;
          trk_buttons = trk_bytes[0][BTN_W-1:0];
          trk_dx = trk_bytes[0][SIGN_X_BIT] ? int'(trk_bytes[1]) - 256 : int'(trk_bytes[1]);
          trk_dy = trk_bytes[0][SIGN_Y_BIT] ? int'(trk_bytes[2]) - 256 : int'(trk_bytes[2]);
          trk_x  = clamp_to(trk_x + trk_dx, cfg_width);
          trk_y  = clamp_to(trk_y - trk_dy, cfg_height);
          r.done = 1'b1;
        end else begin
          trk_index = (trk_index + 1) & 3;
        end
      end
    end
    r.buttons = trk_buttons;
    r.dx      = trk_dx[DELTA_W-1:0];
    r.dy      = trk_dy[DELTA_W-1:0];
    r.x       = trk_x[POS_BITS-1:0];
    r.y       = trk_y[POS_BITS-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_reports.push_back(track_byte(byte_on_bus));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          byte_on_bus = pending_bytes.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.ctrl_status <= byte_on_bus.status;
          in_ch.rx_byte     <= byte_on_bus.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tracker_report_t exp;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual pos %0d,%0d", $time,
                   out_ch.pos_x, out_ch.pos_y);
          errors++;
        end else begin
          exp = expected_reports.pop_front();
          check_field("packet_done", exp.done, out_ch.packet_done);
          check_field("byte_taken", exp.taken, out_ch.byte_taken);
          check_field("button_bits", exp.buttons, out_ch.button_bits);
          check_field("delta_x", exp.dx, $unsigned(out_ch.delta_x));
          check_field("delta_y", exp.dy, $unsigned(out_ch.delta_y));
          check_field("pos_x", exp.x, out_ch.pos_x);
          check_field("pos_y", exp.y, out_ch.pos_y);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_byte(logic [7:0] status, logic [7:0] data);
    mouse_byte_t b;
    b.status = status;
    b.data   = data;
    pending_bytes.push_back(b);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WHEEL_ENABLE:  cfg_wheel  = value[0];
      REG_SCREEN_WIDTH:  cfg_width  = value[SIZE_W-1:0];
      REG_SCREEN_HEIGHT: cfg_height = value[SIZE_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_ignored();
    logic [7:0] st;
    st = 8'($urandom_range(255));
    case ($urandom_range(2))
      0: st[STATUS_DATA_BIT] = 1'b0;
      1: st[STATUS_AUX_BIT] = 1'b0;
      default: begin
        st[STATUS_DATA_BIT] = 1'b0;
        st[STATUS_AUX_BIT]  = 1'b0;
      end
    endcase
    queue_byte(st, 8'($urandom_range(255)));
  endtask

  task automatic fill_random(int n, logic wheel);
    int count;
    int pick;
    logic [7:0] b;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        for (int i = 0; i < (wheel ? 4 : 3); i++) begin
          if ($urandom_range(9) == 0) begin
            queue_ignored();
            count++;
          end
          b = 8'($urandom_range(255));
          if (i == 0) b[SYNC_BIT] = 1'b1;
          queue_byte(8'($urandom_range(255)) | ST_MOUSE, b);
          count++;
        end
      end else if (pick < 90) begin
        queue_byte(8'($urandom_range(255)) | ST_MOUSE, 8'($urandom_range(255)));
        count++;
      end else begin
        queue_ignored();
        count++;
      end
    end
  endtask

  task automatic run_phase(logic wheel, int width, int height, int idle, int stall, int n);
    write_reg(REG_WHEEL_ENABLE, DATA_W'(wheel));
    write_reg(REG_SCREEN_WIDTH, DATA_W'(width));
    write_reg(REG_SCREEN_HEIGHT, DATA_W'(height));
    idle_pct  <= idle;
    stall_pct <= stall;
    fill_random(n, wheel);
    drain();
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.ctrl_status = '0;
    in_ch.rx_byte     = '0;
    out_ch.ready      = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    errors            = 0;
    cycle_count       = 0;
    cfg_wheel         = 1'b0;
    cfg_width         = WIDTH_RESET;
    cfg_height        = HEIGHT_RESET;
    trk_index         = 0;
    trk_x             = 0;
    trk_y             = 0;
    trk_buttons       = '0;
    trk_dx            = 0;
    trk_dy            = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_byte(8'h00, 8'h08);
    queue_byte(8'h01, 8'h08);
    queue_byte(8'h20, 8'h08);
    queue_byte(8'hFE, 8'hFF);
    queue_byte(8'hDF, 8'hFF);
    queue_byte(ST_MOUSE, 8'hF7);
    queue_byte(8'hFF, 8'h00);
    queue_byte(ST_MOUSE, 8'h08);
    queue_byte(ST_MOUSE, 8'h00);
    queue_byte(ST_MOUSE, 8'h00);
    queue_byte(8'hFF, 8'h3F);
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'hFF, 8'h00);
    queue_byte(ST_MOUSE, 8'h0F);
    queue_byte(ST_MOUSE, 8'hFF);
    queue_byte(ST_MOUSE, 8'hFF);
    queue_byte(ST_MOUSE, 8'h28);
    queue_byte(8'h00, 8'h55);
    queue_byte(ST_MOUSE, 8'h80);
    queue_byte(ST_MOUSE, 8'h01);
    drain();

    // Four-byte packets on a zero-sized screen, then a packet length change mid packet.
    write_reg(REG_WHEEL_ENABLE, DATA_W'(1));
    write_reg(REG_SCREEN_WIDTH, DATA_W'(0));
    write_reg(REG_SCREEN_HEIGHT, DATA_W'(0));
    queue_byte(ST_MOUSE, 8'h18);
    queue_byte(ST_MOUSE, 8'h05);
    queue_byte(ST_MOUSE, 8'h80);
    queue_byte(ST_MOUSE, 8'hA5);
    queue_byte(ST_MOUSE, 8'h08);
    queue_byte(ST_MOUSE, 8'h10);
    drain();
    write_reg(REG_WHEEL_ENABLE, DATA_W'(0));
    queue_byte(ST_MOUSE, 8'h20);
    queue_byte(ST_MOUSE, 8'h0A);
    queue_byte(ST_MOUSE, 8'h7F);
    drain();
    write_reg(REG_WHEEL_ENABLE, DATA_W'(1));
    queue_byte(ST_MOUSE, 8'h3E);
    drain();
    write_reg(REG_WHEEL_ENABLE, DATA_W'(0));
    queue_byte(ST_MOUSE, 8'hC3);
    drain();

    run_phase(1'b0, 8191, 4096, 0, 0, 230);
    run_phase(1'b1, 1024, 768, 58, 0, 230);
    run_phase(1'b0, $urandom_range(64, 1), $urandom_range(64, 1), 0, 58, 230);
    run_phase(1'b1, 4096, 1, 18, 18, 220);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
